>>> rtl/ble_adv_manufacturer_filter_top_defines.svh
// Assertion macros for the advertising manufacturer filter.
// Included by the modules that carry assertions; depends on nothing.
`ifndef BLE_ADV_MANUFACTURER_FILTER_TOP_DEFINES_SVH
`define BLE_ADV_MANUFACTURER_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define BAMF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BAMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bamf_pkg.sv
// Shared types and constants of the advertising manufacturer filter.
// No dependencies.
`default_nettype none

package bamf_pkg;

	localparam int MAX_PAYLOAD_BYTES = 32;
	localparam int COUNT_BITS        = 16;
	localparam logic [15:0] MATCH_COMPANY_RST = 16'h004C;
	localparam logic [7:0]  FLAGS_TYPE_RST    = 8'd1;
	localparam logic [7:0]  MANUF_TYPE_RST    = 8'd255;
	localparam logic [7:0]  MIN_MANUF_LEN     = 8'd3;

	localparam logic [1:0] REG_MATCH_COMPANY = 2'd0;
	localparam logic [1:0] REG_FLAGS_TYPE    = 2'd1;
	localparam logic [1:0] REG_MANUF_TYPE    = 2'd2;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		PH_LEN,
		PH_TYPE,
		PH_BODY,
		PH_STOP
	} phase_t;

	typedef enum logic [1:0] {
		ST_PARSE,
		ST_CHECK,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic take_byte;
		logic clear_count;
		logic count_up;
		logic new_packet;
		logic rd_start;
		logic rd_step;
	} ctl_cmd_t;

	typedef struct packed {
		logic match;
		logic rd_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

>>> rtl/bamf_datapath.sv
// Parser registers, record memory, readout and output register.
// Depends on bamf_pkg; driven by bamf_ctrl.
`default_nettype none

module bamf_datapath #(
	parameter int MAX_PAYLOAD_BYTES = bamf_pkg::MAX_PAYLOAD_BYTES,
	parameter int COUNT_BITS        = bamf_pkg::COUNT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bamf_pkg::ctl_cmd_t    cmd,
	output bamf_pkg::dp_status_t       sts,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  cfg_wr_en,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [15:0]           cfg_wdata,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [7:0]                 out_byte,
	output logic                       out_kind,
	output logic                       out_last,
	output logic [15:0]                out_count
);

	localparam int IW    = $clog2(MAX_PAYLOAD_BYTES);
	localparam int LW    = $clog2(MAX_PAYLOAD_BYTES + 1);
	localparam int DEPTH = 3 * (1 << IW);

	logic [7:0] mem [DEPTH];

	logic [15:0] match_q;
	logic [7:0]  flags_type_q;
	logic [7:0]  manuf_type_q;

	logic [LW-1:0]        pos_q;
	bamf_pkg::phase_t     phase_q;
	logic [7:0]           rem_q;
	logic [7:0]           len_q;
	logic [IW-1:0]        idx_q;
	logic [7:0]           type_q;
	logic [7:0]           co_lo_q;
	logic [7:0]           co_hi_q;
	logic [LW-1:0]        flags_len_q;
	logic [LW-1:0]        manuf_len_q;
	logic [1:0]           stage_bank_q;
	logic [1:0]           flags_bank_q;
	logic [1:0]           manuf_bank_q;
	logic [COUNT_BITS-1:0] count_q;

	logic          rd_kind_q;
	logic [IW-1:0] rd_idx_q;
	logic          out_valid_q;
	logic          out_kind_q;
	logic          out_last_q;
	logic [15:0]   out_count_q;
	logic [7:0]    rdata_q;

	logic                     pos_full;
	logic                     active;
	logic                     wr_en;
	logic [IW+1:0]            wr_addr;
	logic [IW+1:0]            rd_addr;
	logic [7:0]               cur_type;
	logic [7:0]               cur_co_hi;
	logic                     ends;
	logic                     is_flags;
	logic                     is_manuf;
	logic                     commit_flags;
	logic                     commit_manuf;
	logic [8:0]               len_p1;
	logic [LW-1:0]            rec_len;
	logic [LW-1:0]            rd_len;
	logic                     rd_rec_end;
	logic [COUNT_BITS+15:0]   count_ext;

	assign pos_full  = pos_q >= LW'(MAX_PAYLOAD_BYTES);
	assign active    = cmd.take_byte && (phase_q != bamf_pkg::PH_STOP) && !pos_full;
	assign wr_en     = active && !((phase_q == bamf_pkg::PH_LEN) && (in_byte == 8'd0));
	assign wr_addr   = {stage_bank_q, (phase_q == bamf_pkg::PH_LEN) ? IW'(0) : idx_q};
	assign cur_type  = (phase_q == bamf_pkg::PH_TYPE) ? in_byte : type_q;
	assign cur_co_hi = (idx_q == IW'(3)) ? in_byte : co_hi_q;
	assign ends      = active && (phase_q != bamf_pkg::PH_LEN) && (rem_q == 8'd1);
	assign is_flags  = cur_type == flags_type_q;
	assign is_manuf  = !is_flags && (cur_type == manuf_type_q)
		&& (len_q >= bamf_pkg::MIN_MANUF_LEN) && ({cur_co_hi, co_lo_q} == match_q);
	assign commit_flags = ends && is_flags;
	assign commit_manuf = ends && is_manuf;
	assign len_p1    = {1'b0, len_q} + 9'd1;
	assign rec_len   = len_p1[LW-1:0];

	assign rd_len     = rd_kind_q ? manuf_len_q : flags_len_q;
	assign rd_rec_end = (LW'(rd_idx_q) + LW'(1)) == rd_len;
	assign rd_addr    = {rd_kind_q ? manuf_bank_q : flags_bank_q, rd_idx_q};
	assign count_ext  = {16'd0, count_q};

	assign sts.match    = manuf_len_q != '0;
	assign sts.rd_last  = rd_kind_q && rd_rec_end;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_byte  = rdata_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;
	assign out_count = out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q      <= bamf_pkg::MATCH_COMPANY_RST;
			flags_type_q <= bamf_pkg::FLAGS_TYPE_RST;
			manuf_type_q <= bamf_pkg::MANUF_TYPE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bamf_pkg::REG_MATCH_COMPANY: match_q      <= cfg_wdata;
				bamf_pkg::REG_FLAGS_TYPE:    flags_type_q <= cfg_wdata[7:0];
				bamf_pkg::REG_MANUF_TYPE:    manuf_type_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			phase_q      <= bamf_pkg::PH_LEN;
			rem_q        <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			type_q       <= '0;
			co_lo_q      <= '0;
			co_hi_q      <= '0;
			flags_len_q  <= '0;
			manuf_len_q  <= '0;
			stage_bank_q <= 2'd0;
			flags_bank_q <= 2'd1;
			manuf_bank_q <= 2'd2;
		end else if (cmd.new_packet) begin
			pos_q       <= '0;
			phase_q     <= bamf_pkg::PH_LEN;
			rem_q       <= '0;
			type_q      <= '0;
			co_lo_q     <= '0;
			flags_len_q <= '0;
			manuf_len_q <= '0;
		end else if (cmd.take_byte && phase_q != bamf_pkg::PH_STOP) begin
			if (pos_full) begin
				phase_q <= bamf_pkg::PH_STOP;
			end else begin
				pos_q <= pos_q + LW'(1);
				if (phase_q == bamf_pkg::PH_LEN) begin
					if (in_byte == 8'd0) begin
						phase_q <= bamf_pkg::PH_STOP;
					end else begin
						len_q   <= in_byte;
						rem_q   <= in_byte;
						idx_q   <= IW'(1);
						phase_q <= bamf_pkg::PH_TYPE;
					end
				end else begin
					idx_q <= idx_q + IW'(1);
					rem_q <= rem_q - 8'd1;
					if (phase_q == bamf_pkg::PH_TYPE)
						type_q <= in_byte;
					if (idx_q == IW'(2))
						co_lo_q <= in_byte;
					if (idx_q == IW'(3))
						co_hi_q <= in_byte;
					if (rem_q == 8'd1)
						phase_q <= bamf_pkg::PH_LEN;
					else if (phase_q == bamf_pkg::PH_TYPE)
						phase_q <= bamf_pkg::PH_BODY;
					// kept records swap banks with the staging bank
					if (commit_flags) begin
						flags_len_q  <= rec_len;
						flags_bank_q <= stage_bank_q;
						stage_bank_q <= flags_bank_q;
					end else if (commit_manuf) begin
						manuf_len_q  <= rec_len;
						manuf_bank_q <= stage_bank_q;
						stage_bank_q <= manuf_bank_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear_count) begin
			count_q <= '0;
		end else if (cmd.count_up && count_q != '1) begin
			count_q <= count_q + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_kind_q   <= 1'b0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rd_start) begin
				rd_kind_q <= flags_len_q == '0;
				rd_idx_q  <= '0;
			end else if (cmd.rd_step) begin
				if (rd_rec_end) begin
					rd_kind_q <= 1'b1;
					rd_idx_q  <= '0;
				end else begin
					rd_idx_q <= rd_idx_q + IW'(1);
				end
			end
			if (cmd.rd_step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_step) begin
			out_kind_q  <= rd_kind_q;
			out_last_q  <= sts.rd_last;
			out_count_q <= count_ext[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= in_byte;
		if (cmd.rd_step)
			rdata_q <= mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> rtl/bamf_ctrl.sv
// Controller: intake, end-of-packet check and record readout sequencing.
// Depends on bamf_pkg and the assertion macro header.
`default_nettype none

`include "ble_adv_manufacturer_filter_top_defines.svh"

module bamf_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_cmd,
	input  wire logic                 in_last,
	output logic                      in_ready,
	input  wire bamf_pkg::dp_status_t sts,
	output bamf_pkg::ctl_cmd_t        cmd
);

	bamf_pkg::ctl_state_t state_q;
	bamf_pkg::ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bamf_pkg::ST_PARSE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			bamf_pkg::ST_PARSE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_cmd == bamf_pkg::CMD_CLEAR) begin
						cmd.clear_count = 1'b1;
					end else begin
						cmd.take_byte = 1'b1;
						if (in_last)
							state_d = bamf_pkg::ST_CHECK;
					end
				end
			end
			bamf_pkg::ST_CHECK: begin
				if (sts.match) begin
					cmd.count_up = 1'b1;
					cmd.rd_start = 1'b1;
					state_d      = bamf_pkg::ST_EMIT;
				end else begin
					cmd.new_packet = 1'b1;
					state_d        = bamf_pkg::ST_PARSE;
				end
			end
			bamf_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.rd_step = 1'b1;
					if (sts.rd_last) begin
						cmd.new_packet = 1'b1;
						state_d        = bamf_pkg::ST_PARSE;
					end
				end
			end
			default: begin
				state_d = bamf_pkg::ST_PARSE;
			end
		endcase
	end

	`BAMF_ASSERT_NEXT(a_last_to_check, clk, arst_n, in_valid && in_ready && in_cmd == bamf_pkg::CMD_BYTE && in_last, state_q == bamf_pkg::ST_CHECK, "last byte did not start the check")
	`BAMF_ASSERT_NEXT(a_check_once, clk, arst_n, state_q == bamf_pkg::ST_CHECK, state_q != bamf_pkg::ST_CHECK, "check state held")
	`BAMF_ASSERT_NEXT(a_match_emits, clk, arst_n, state_q == bamf_pkg::ST_CHECK && sts.match, state_q == bamf_pkg::ST_EMIT, "match did not start readout")
	`BAMF_ASSERT_SAME(a_emit_has_record, clk, arst_n, state_q == bamf_pkg::ST_EMIT, sts.match, "readout without a kept record")

endmodule

`default_nettype wire

>>> rtl/ble_adv_manufacturer_filter_top.sv
// Top level of the advertising manufacturer filter: ports, controller, datapath.
// Depends on bamf_pkg, bamf_ctrl and bamf_datapath.
//
// channel   dir  tdata                          tuser        tlast
// s_axis    in   [7:0] adv_byte                 command      last_byte
// m_axis    out  [7:0] out_byte, [23:8] count   record_kind  last
// cfg       in   write port, index 0..2, 16-bit data, no read-back
//
// A payload or clear beat is taken while parsing. A last byte leads to the check state; on a
// match the records leave at one beat per cycle while the output is ready, flags_len +
// manuf_len beats (at most MAX_PAYLOAD_BYTES), paced by the single read port of the record
// memory; intake waits. Output stalls hold the output register and pause the readout. Reset
// is asynchronous and needs no clearing pass; the record memory is not reset.
`default_nettype none

module ble_adv_manufacturer_filter_top #(
	parameter int MAX_PAYLOAD_BYTES = bamf_pkg::MAX_PAYLOAD_BYTES,
	parameter int COUNT_BITS        = bamf_pkg::COUNT_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] adv_byte
	input  wire logic        s_axis_tuser,   // command
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [23:8] packet_count
	output logic             m_axis_tuser,   // record_kind
	output logic             m_axis_tlast,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	bamf_pkg::ctl_cmd_t   cmd;
	bamf_pkg::dp_status_t sts;
	logic [7:0]           out_byte;
	logic [15:0]          out_count;

	bamf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bamf_datapath #(
		.MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
		.COUNT_BITS        (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_byte   (s_axis_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_byte  (out_byte),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast),
		.out_count (out_count)
	);

	assign m_axis_tdata = {out_count, out_byte};

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for ble_adv_manufacturer_filter_top: directed and random
// advertising payloads, with a scoreboard that predicts every emitted record beat.
// Depends on bamf_pkg and the RTL of the filter.
`timescale 1ns / 100ps

module tb;

	localparam logic KIND_FLAGS = 1'b0;
	localparam logic KIND_MANUF = 1'b1;

	typedef struct packed {
		logic [7:0]  data;
		logic        kind;
		logic        last;
		logic [15:0] count;
	} record_beat_t;

	typedef enum {SK_FLAGS, SK_MATCH, SK_MISS, SK_SHORT, SK_OTHER} struct_kind_t;

	class adv_filter_scoreboard;
		logic [15:0] company;
		logic [7:0]  flags_type;
		logic [7:0]  manuf_type;

		int               pos;
		bamf_pkg::phase_t phase;
		int               remain;
		logic [7:0]       cur_type;
		logic [7:0]       company_lo;
		logic [7:0]       staging   [bamf_pkg::MAX_PAYLOAD_BYTES];
		logic [7:0]       flags_rec [bamf_pkg::MAX_PAYLOAD_BYTES];
		logic [7:0]       manuf_rec [bamf_pkg::MAX_PAYLOAD_BYTES];
		int               flags_len;
		int               manuf_len;
		logic [bamf_pkg::COUNT_BITS-1:0] matched;

		record_beat_t expected[$];
		int errors;
		int checked;
		int matched_pkts;

		function new();
			company      = bamf_pkg::MATCH_COMPANY_RST;
			flags_type   = bamf_pkg::FLAGS_TYPE_RST;
			manuf_type   = bamf_pkg::MANUF_TYPE_RST;
			matched      = '0;
			errors       = 0;
			checked      = 0;
			matched_pkts = 0;
			open_packet();
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				bamf_pkg::REG_MATCH_COMPANY: company = val;
				bamf_pkg::REG_FLAGS_TYPE: flags_type = val[7:0];
				bamf_pkg::REG_MANUF_TYPE: manuf_type = val[7:0];
				default: ;
			endcase
		endfunction

		function void open_packet();
			pos        = 0;
			phase      = bamf_pkg::PH_LEN;
			remain     = 0;
			cur_type   = '0;
			company_lo = '0;
			flags_len  = 0;
			manuf_len  = 0;
		endfunction

		// structure complete: keep it if it is flags or a matching manufacturer one
		function void close_structure();
			int total;
			int i;
			total = int'(staging[0]) + 1;
			if (total > bamf_pkg::MAX_PAYLOAD_BYTES)
				return;
			if (cur_type == flags_type) begin
				for (i = 0; i < total; i++)
					flags_rec[i] = staging[i];
				flags_len = total;
			end else if (cur_type == manuf_type && staging[0] >= bamf_pkg::MIN_MANUF_LEN) begin
				if ({staging[3], company_lo} == company) begin
					for (i = 0; i < total; i++)
						manuf_rec[i] = staging[i];
					manuf_len = total;
				end
			end
		endfunction

		function void parse_byte(logic [7:0] b);
			int idx;
			if (phase == bamf_pkg::PH_STOP)
				return;
			if (pos >= bamf_pkg::MAX_PAYLOAD_BYTES) begin
				phase = bamf_pkg::PH_STOP;
				return;
			end
			pos++;
			if (phase == bamf_pkg::PH_LEN) begin
				if (b == 8'h00) begin
					phase = bamf_pkg::PH_STOP;
					return;
				end
				staging[0] = b;
				remain     = int'(b);
				phase      = bamf_pkg::PH_TYPE;
				return;
			end
			idx = int'(staging[0]) + 1 - remain;
			if (idx < bamf_pkg::MAX_PAYLOAD_BYTES)
				staging[idx] = b;
			if (phase == bamf_pkg::PH_TYPE) begin
				cur_type = b;
				phase    = bamf_pkg::PH_BODY;
			end
			if (idx == 2)
				company_lo = b;
			remain--;
			if (remain == 0) begin
				close_structure();
				phase = bamf_pkg::PH_LEN;
			end
		endfunction

		function void note_input(logic cmd, logic [7:0] b, logic lst);
			record_beat_t r;
			int total;
			int n;
			int i;
			if (cmd == bamf_pkg::CMD_CLEAR) begin
				matched = '0;
				return;
			end
			parse_byte(b);
			if (!lst)
				return;
			if (manuf_len > 0) begin
				if (matched != '1)
					matched++;
				matched_pkts++;
				total = flags_len + manuf_len;
				n = 0;
				for (i = 0; i < flags_len; i++) begin
					r.data  = flags_rec[i];
					r.kind  = KIND_FLAGS;
					r.last  = (n + 1 == total);
					r.count = matched[15:0];
					expected.push_back(r);
					n++;
				end
				for (i = 0; i < manuf_len; i++) begin
					r.data  = manuf_rec[i];
					r.kind  = KIND_MANUF;
					r.last  = (n + 1 == total);
					r.count = matched[15:0];
					expected.push_back(r);
					n++;
				end
			end
			open_packet();
		endfunction

		task report(string what, int got, int want);
			errors++;
			$display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		endtask

		task check(logic [7:0] data, logic [15:0] cnt, logic kind, logic lst);
			record_beat_t e;
			checked++;
			if (expected.size() == 0) begin
				report("unexpected beat", data, 0);
				return;
			end
			e = expected.pop_front();
			if (data !== e.data)
				report("out_byte", data, e.data);
			if (cnt !== e.count)
				report("packet_count", cnt, e.count);
			if (kind !== e.kind)
				report("record_kind", kind, e.kind);
			if (lst !== e.last)
				report("last", lst, e.last);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [23:0] m_axis_tdata;
	wire         m_axis_tuser;
	wire         m_axis_tlast;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	adv_filter_scoreboard sb;
	logic [7:0] pkt[$];
	bit tx_gaps_on = 1'b1;
	bit rx_stall_on = 1'b1;
	int beats_sent = 0;
	int clears_sent = 0;

	ble_adv_manufacturer_filter_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	// output side: random stalls, or always ready
	initial begin
		int g;
		forever begin
			m_axis_tready <= 1'b1;
			if (!rx_stall_on) begin
				@(posedge clk);
			end else begin
				repeat ($urandom_range(1, 12)) @(posedge clk);
				g = gap_len();
				if (g > 0) begin
					m_axis_tready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tuser, m_axis_tlast);
	end

	task automatic send_beat(logic cmd, logic [7:0] b, logic lst);
		int gap;
		gap = tx_gaps_on ? gap_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= b;
		s_axis_tlast  <= lst;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(cmd, b, lst);
		beats_sent++;
		if (cmd == bamf_pkg::CMD_CLEAR)
			clears_sent++;
	endtask

	// clear beats land at random points, mid-packet included
	task automatic send_pkt();
		int i;
		for (i = 0; i < pkt.size(); i++) begin
			if ($urandom_range(0, 99) < 3)
				send_beat(bamf_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom));
			send_beat(bamf_pkg::CMD_BYTE, pkt[i], i == pkt.size() - 1);
		end
		pkt.delete();
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic struct_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return SK_MATCH;
		if (r < 60)
			return SK_FLAGS;
		if (r < 72)
			return SK_MISS;
		if (r < 82)
			return SK_SHORT;
		return SK_OTHER;
	endfunction

	task automatic push_struct(struct_kind_t k);
		int n;
		logic [15:0] co;
		co = sb.company;
		case (k)
			SK_FLAGS: begin
				n = $urandom_range(1, 4);
				pkt.push_back(8'(n));
				pkt.push_back(sb.flags_type);
				repeat (n - 1) pkt.push_back(8'($urandom));
			end
			SK_MATCH, SK_MISS: begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
				if (k == SK_MISS)
					co = co ^ 16'($urandom_range(1, 65535));
				pkt.push_back(8'(n + 3));
				pkt.push_back(sb.manuf_type);
				pkt.push_back(co[7:0]);
				pkt.push_back(co[15:8]);
				repeat (n) pkt.push_back(8'($urandom));
			end
			SK_SHORT: begin
				n = $urandom_range(1, 2);
				pkt.push_back(8'(n));
				pkt.push_back(sb.manuf_type);
				if (n == 2)
					pkt.push_back(co[7:0]);
			end
			default: begin
				n = $urandom_range(1, 6);
				pkt.push_back(8'(n));
				repeat (n) pkt.push_back(8'($urandom));
			end
		endcase
	endtask

	// mostly well-formed packets; some truncated, zero-terminated, noise or overlong
	task automatic build_packet();
		int mode;
		pkt.delete();
		mode = $urandom_range(0, 99);
		if (mode < 8) begin
			repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
			return;
		end
		repeat ($urandom_range(1, 4)) push_struct(pick_kind());
		if (mode < 70)
			return;
		if (mode < 80) begin
			repeat ($urandom_range(1, 3))
				if (pkt.size() > 1)
					pkt.delete(pkt.size() - 1);
		end else if (mode < 90) begin
			if ($urandom_range(0, 3) == 0)
				pkt.push_front(8'h00);
			else
				pkt.push_back(8'h00);
			repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
		end else begin
			while (pkt.size() <= bamf_pkg::MAX_PAYLOAD_BYTES + 2)
				push_struct(pick_kind());
		end
	endtask

	task automatic run_random(int beats);
		int stop;
		stop = beats_sent + beats;
		while (beats_sent < stop) begin
			build_packet();
			send_pkt();
		end
	endtask

	initial begin
		logic [7:0] v;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		pkt = {8'h02, 8'h01, 8'h06, 8'h05, 8'hFF, 8'h4C, 8'h00, 8'hAA, 8'h55};
		send_pkt();
		send_beat(bamf_pkg::CMD_CLEAR, 8'hFF, 1'b1);
		pkt = {8'h03, 8'hFF, 8'h4C};
		send_pkt();
		pkt = {8'h03, 8'hFF, 8'h4C, 8'h01, 8'h00, 8'h03, 8'hFF, 8'h4C, 8'h00};
		send_pkt();
		pkt = {8'h02, 8'hFF, 8'h4C, 8'h01, 8'h01, 8'h03, 8'hFF, 8'h4C, 8'h00};
		send_pkt();
		// largest record fills the payload, then the limit cuts the rest
		pkt = {8'h1F, 8'hFF, 8'h4C, 8'h00};
		repeat (28) pkt.push_back(8'($urandom));
		pkt.push_back(8'h03);
		pkt.push_back(8'hFF);
		send_pkt();
		drain();

		cfg_write(bamf_pkg::REG_MATCH_COMPANY, 16'hFFFF);
		cfg_write(bamf_pkg::REG_FLAGS_TYPE, 16'h0000);
		cfg_write(bamf_pkg::REG_MANUF_TYPE, 16'h0080);
		run_random(15);
		drain();
		run_random(15);
		drain();

		cfg_write(bamf_pkg::REG_MATCH_COMPANY, 16'h0000);
		cfg_write(bamf_pkg::REG_FLAGS_TYPE, 16'h00FF);
		cfg_write(bamf_pkg::REG_MANUF_TYPE, 16'h0000);
		run_random(30);
		drain();

		// one code for both types: flags wins
		v = 8'($urandom);
		cfg_write(bamf_pkg::REG_FLAGS_TYPE, {8'h00, v});
		cfg_write(bamf_pkg::REG_MANUF_TYPE, {8'h00, v});
		cfg_write(bamf_pkg::REG_MATCH_COMPANY, 16'($urandom));
		run_random(30);
		drain();

		cfg_write(bamf_pkg::REG_MATCH_COMPANY, 16'($urandom));
		cfg_write(bamf_pkg::REG_FLAGS_TYPE, 16'($urandom_range(0, 255)));
		cfg_write(bamf_pkg::REG_MANUF_TYPE, 16'($urandom_range(0, 255)));
		tx_gaps_on  = 1'b0;
		rx_stall_on = 1'b0;
		run_random(15);
		tx_gaps_on  = 1'b1;
		rx_stall_on = 1'b1;
		run_random(20);
		drain();

		// back-to-back minimal matches, count cleared around them
		cfg_write(bamf_pkg::REG_MATCH_COMPANY, bamf_pkg::MATCH_COMPANY_RST);
		cfg_write(bamf_pkg::REG_FLAGS_TYPE, {8'h00, bamf_pkg::FLAGS_TYPE_RST});
		cfg_write(bamf_pkg::REG_MANUF_TYPE, {8'h00, bamf_pkg::MANUF_TYPE_RST});
		tx_gaps_on  = 1'b0;
		rx_stall_on = 1'b0;
		send_beat(bamf_pkg::CMD_CLEAR, 8'h00, 1'b0);
		repeat (4) begin
			send_beat(bamf_pkg::CMD_BYTE, 8'h03, 1'b0);
			send_beat(bamf_pkg::CMD_BYTE, bamf_pkg::MANUF_TYPE_RST, 1'b0);
			send_beat(bamf_pkg::CMD_BYTE, bamf_pkg::MATCH_COMPANY_RST[7:0], 1'b0);
			send_beat(bamf_pkg::CMD_BYTE, bamf_pkg::MATCH_COMPANY_RST[15:8], 1'b1);
		end
		send_beat(bamf_pkg::CMD_CLEAR, 8'h00, 1'b0);
		pkt = {8'h03, 8'hFF, 8'h4C, 8'h00};
		send_pkt();
		drain();

		$display("covered %0d input beats (%0d clears), %0d record beats, %0d matching packets",
			beats_sent, clears_sent, sb.checked, sb.matched_pkts);
		$display("register sets: reset, extremes, shared type code, random; count cleared");
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bamf_pkg.sv
rtl/bamf_datapath.sv
rtl/bamf_ctrl.sv
rtl/ble_adv_manufacturer_filter_top.sv
tb/sv/tb.sv
